### src/nsd_pkg.sv
// Shared types, constants and pitch tables for the note sequencer tone divider.
package nsd_pkg;

    localparam int CLOCK_HZ_DEFAULT = 16000000;

    localparam int CODE_W   = 4;
    localparam int VALUE_W  = 3;
    localparam int DATA_W   = 16;
    localparam int TABLE_W  = 14;
    localparam int OCT_W    = 4;
    localparam int MAX_UP   = 7;
    localparam int FREQ_W   = TABLE_W + MAX_UP;

    localparam logic [DATA_W-1:0] WHOLE_NOTE_RESET = DATA_W'(1000);
    localparam logic [DATA_W-1:0] DIV_MAX          = '1;

    localparam logic [CODE_W-1:0] CODE_PAUSE = CODE_W'(0);
    localparam logic [CODE_W-1:0] CODE_FLAG  = CODE_W'(15);

    localparam logic [VALUE_W-1:0] FLAG_SHARP    = VALUE_W'(0);
    localparam logic [VALUE_W-1:0] FLAG_DOT      = VALUE_W'(1);
    localparam logic [VALUE_W-1:0] FLAG_OCT_UP   = VALUE_W'(2);
    localparam logic [VALUE_W-1:0] FLAG_OCT_DOWN = VALUE_W'(3);

    localparam logic signed [OCT_W-1:0] OCT_HIGH = OCT_W'(7);
    localparam logic signed [OCT_W-1:0] OCT_LOW  = OCT_W'(-8);

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } nsd_cmd_t;

    typedef struct packed {
        logic needs_div;
        logic div_last;
    } nsd_status_t;

    // pitch frequency in 0.1 Hz, C4..B5
    function automatic logic [TABLE_W-1:0] natural_freq(input logic [CODE_W-1:0] code);
        logic [TABLE_W-1:0] f;
        unique case (code)
            4'd1:    f = TABLE_W'(2616);
            4'd2:    f = TABLE_W'(2937);
            4'd3:    f = TABLE_W'(3296);
            4'd4:    f = TABLE_W'(3492);
            4'd5:    f = TABLE_W'(3919);
            4'd6:    f = TABLE_W'(4400);
            4'd7:    f = TABLE_W'(4939);
            4'd8:    f = TABLE_W'(5233);
            4'd9:    f = TABLE_W'(5873);
            4'd10:   f = TABLE_W'(6593);
            4'd11:   f = TABLE_W'(6985);
            4'd12:   f = TABLE_W'(7840);
            4'd13:   f = TABLE_W'(8800);
            4'd14:   f = TABLE_W'(9878);
            default: f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [TABLE_W-1:0] sharp_freq(input logic [CODE_W-1:0] code);
        logic [TABLE_W-1:0] f;
        unique case (code)
            4'd1:    f = TABLE_W'(2772);
            4'd2:    f = TABLE_W'(3111);
            4'd3:    f = TABLE_W'(3296);
            4'd4:    f = TABLE_W'(3700);
            4'd5:    f = TABLE_W'(4153);
            4'd6:    f = TABLE_W'(4662);
            4'd7:    f = TABLE_W'(4939);
            4'd8:    f = TABLE_W'(5544);
            4'd9:    f = TABLE_W'(6223);
            4'd10:   f = TABLE_W'(6593);
            4'd11:   f = TABLE_W'(7400);
            4'd12:   f = TABLE_W'(8306);
            4'd13:   f = TABLE_W'(9323);
            4'd14:   f = TABLE_W'(9878);
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

### src/nsd_ctrl.sv
// Control state machine: sequences load, divide steps and result commit.
module nsd_ctrl
    import nsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  nsd_status_t status,
    output nsd_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.needs_div ? S_DIV : S_DONE;
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output word to be taken
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result committed over an untaken word");

    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg != S_IDLE))
        else $error("load did not leave idle");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && status.div_last) |=> (state_reg == S_DONE))
        else $error("divide did not finish on its last step");

endmodule

### src/nsd_datapath.sv
// Datapath: note state, pitch lookup, restoring divider and result registers.
module nsd_datapath
    import nsd_pkg::*;
#(
    parameter int CLOCK_HZ = CLOCK_HZ_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CODE_W-1:0]   note_code,
    input  logic [VALUE_W-1:0]  note_value,
    input  logic                cfg_valid,
    input  logic [DATA_W-1:0]   whole_note_ms,
    input  nsd_cmd_t            cmd,
    output nsd_status_t         status,
    output logic [DATA_W-1:0]   tone_divider,
    output logic                divider_changed,
    output logic [DATA_W-1:0]   duration_ms
);

    localparam longint BASE  = (longint'(CLOCK_HZ) / 8) * 10;
    localparam int     QUO_W = $clog2(BASE + 1);
    localparam int     CNT_W = $clog2(QUO_W);

    // configuration and note state
    logic [DATA_W-1:0]       whole_reg;
    logic                    sharp_reg, sharp_next;
    logic signed [OCT_W-1:0] oct_reg, oct_next;
    logic [DATA_W-1:0]       last_reg, last_next;
    logic [DATA_W-1:0]       cur_div_reg, cur_div_next;

    // latched item and divider
    logic [CODE_W-1:0]  code_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic [FREQ_W-1:0]  rem_reg;
    logic [QUO_W-1:0]   dvd_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // result word
    logic [DATA_W-1:0] tone_reg, tone_next;
    logic              changed_reg, changed_next;
    logic [DATA_W-1:0] dur_reg, dur_next;

    logic [TABLE_W-1:0] tbl_freq;
    logic [FREQ_W-1:0]  shifted_freq;
    logic [OCT_W-1:0]   down_amt;
    logic [FREQ_W:0]    trial;
    logic [FREQ_W:0]    diff;
    logic               ge;
    logic [DATA_W-1:0]  quot_sat;
    logic [DATA_W-1:0]  note_div;

    assign status.needs_div = (note_code != CODE_FLAG) && (note_code != CODE_PAUSE);
    assign status.div_last  = (cnt_reg == CNT_W'(QUO_W - 1));

    // frequency for the incoming note, shifted by octave
    always_comb
    begin
        tbl_freq = sharp_reg ? sharp_freq(note_code) : natural_freq(note_code);
        down_amt = OCT_W'(-oct_reg);
        if (oct_reg < 0)
            shifted_freq = FREQ_W'(tbl_freq) >> down_amt;
        else
            shifted_freq = FREQ_W'(tbl_freq) << oct_reg[OCT_W-2:0];
    end

    // one restoring step: quotient bits shift in where dividend bits leave
    assign trial = {rem_reg, dvd_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, freq_reg};
    assign ge    = (trial >= {1'b0, freq_reg});

    assign quot_sat = (|dvd_reg[QUO_W-1:DATA_W]) ? DIV_MAX : dvd_reg[DATA_W-1:0];
    assign note_div = (code_reg == CODE_PAUSE) ? '0 : quot_sat;

    always_comb
    begin
        sharp_next   = sharp_reg;
        oct_next     = oct_reg;
        last_next    = last_reg;
        cur_div_next = cur_div_reg;
        tone_next    = cur_div_reg;
        changed_next = 1'b0;
        dur_next     = '0;
        if (code_reg == CODE_FLAG)
        begin
            unique case (value_reg)
                FLAG_SHARP:
                    sharp_next = 1'b1;
                FLAG_DOT:
                begin
                    last_next = last_reg >> 1;
                    dur_next  = last_reg >> 1;
                end
                FLAG_OCT_UP:
                begin
                    if (oct_reg != OCT_HIGH)
                        oct_next = oct_reg + OCT_W'(1);
                end
                FLAG_OCT_DOWN:
                begin
                    if (oct_reg != OCT_LOW)
                        oct_next = oct_reg - OCT_W'(1);
                end
                default: ;
            endcase
        end
        else
        begin
            tone_next    = note_div;
            changed_next = (note_div != cur_div_reg);
            cur_div_next = note_div;
            dur_next     = whole_reg >> value_reg;
            last_next    = whole_reg >> value_reg;
            sharp_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_reg   <= WHOLE_NOTE_RESET;
            sharp_reg   <= 1'b0;
            oct_reg     <= '0;
            last_reg    <= '0;
            cur_div_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
                whole_reg <= whole_note_ms;
            if (cmd.load)
                cnt_reg <= '0;
            else if (cmd.step)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (cmd.commit)
            begin
                sharp_reg   <= sharp_next;
                oct_reg     <= oct_next;
                last_reg    <= last_next;
                cur_div_reg <= cur_div_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg  <= note_code;
            value_reg <= note_value;
            freq_reg  <= shifted_freq;
            rem_reg   <= '0;
            dvd_reg   <= QUO_W'(BASE);
        end
        else if (cmd.step)
        begin
            rem_reg <= ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
            dvd_reg <= {dvd_reg[QUO_W-2:0], ge};
        end
        if (cmd.commit)
        begin
            tone_reg    <= tone_next;
            changed_reg <= changed_next;
            dur_reg     <= dur_next;
        end
    end

    assign tone_divider    = tone_reg;
    assign divider_changed = changed_reg;
    assign duration_ms     = dur_reg;

    a_tone_tracks_current: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (tone_reg == cur_div_reg))
        else $error("output divider differs from divider in use");

    a_restart_means_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && changed_next) |=> (cur_div_reg != $past(cur_div_reg)))
        else $error("restart flagged without a divider change");

    a_flag_keeps_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && code_reg == CODE_FLAG) |=> !changed_reg)
        else $error("flag word flagged a restart");

endmodule

### src/note_sequencer_tone_divider_core.sv
// Note sequencer tone divider: top level joining controller and datapath.
//
// Input channel (in_valid/in_ready) takes one word per note: note_code 0 is a
// pause, 1..14 are pitches C4..B5, 15 is a flag whose note_value selects sharp,
// dot, octave up or octave down. For notes note_value is the length exponent.
// Output channel (out_valid/out_ready) gives one word per input word:
// tone_divider (timer period in clock/8 ticks, 0 = tone off), divider_changed
// (counter restart) and duration_ms.
// Config channel (cfg_valid/cfg_ready) writes whole_note_ms; always ready.
// whole_note_ms must be written only while the block is idle; the block does not enforce this.
// Flags and pauses go from accept straight to the result commit; pitches first
// pass through the restoring divider, one quotient bit per cycle over QUO_W bits,
// QUO_W being the bit width of (CLOCK_HZ/8)*10 (25 bits at 16 MHz).
// One word is in work at a time; the next word is taken once the previous
// result sits in the output register, so throughput equals latency while the
// receiver keeps up.
// Reset clears sharp, octave, last duration and the divider in use (tone off)
// and sets whole_note_ms to 1000. A stalled receiver holds the finished word
// in the output register; the next word then waits in the controller.
module note_sequencer_tone_divider_core
    import nsd_pkg::*;
#(
    parameter int CLOCK_HZ = CLOCK_HZ_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CODE_W-1:0]  note_code,
    input  logic [VALUE_W-1:0] note_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DATA_W-1:0]  tone_divider,
    output logic               divider_changed,
    output logic [DATA_W-1:0]  duration_ms,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [DATA_W-1:0]  whole_note_ms
);

    nsd_cmd_t    cmd;
    nsd_status_t status;

    assign cfg_ready = 1'b1;

    nsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    nsd_datapath #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .note_code       (note_code),
        .note_value      (note_value),
        .cfg_valid       (cfg_valid),
        .whole_note_ms   (whole_note_ms),
        .cmd             (cmd),
        .status          (status),
        .tone_divider    (tone_divider),
        .divider_changed (divider_changed),
        .duration_ms     (duration_ms)
    );

endmodule
